/* hdl/b64lw_pkg.sv */
`default_nettype none

package b64lw_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_WRAP_ENABLE = 2'd0;
    localparam logic [1:0] CFG_LINE_GROUPS = 2'd1;

    localparam logic [7:0] CHAR_PAD = 8'd61;
    localparam logic [7:0] CHAR_CR  = 8'd13;
    localparam logic [7:0] CHAR_LF  = 8'd10;

    localparam logic [6:0] COL_MAX = 7'd127;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_b64lw_in;

    typedef struct packed {
        logic [7:0] out_char;
        logic       out_last;
    } t_b64lw_out;

    // one classified byte: up to four symbols/pads, optional line break, end flag
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [2:0]      nsym;
        logic            crlf;
        logic            last;
    } t_b64lw_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_b64lw_qstat;

    function automatic logic [7:0] b64_char(input logic [5:0] six);
        logic [7:0] v;
        v = {2'b00, six};
        if (six < 6'd26) begin
            b64_char = 8'd65 + v;
        end else if (six < 6'd52) begin
            b64_char = 8'd71 + v;
        end else if (six < 6'd62) begin
            b64_char = v - 8'd4;
        end else if (six == 6'd62) begin
            b64_char = 8'd43;
        end else begin
            b64_char = 8'd47;
        end
    endfunction

endpackage

`default_nettype wire

/* hdl/base64_encoder_line_wrap_unit.sv */
// Streaming Base64 encoder with optional CR LF line wrapping.
// Input channel: one message byte per beat (i_in_valid / o_in_stall), with
// final_byte set on the last byte of a message. Output channel: one ASCII
// character per beat (o_out_valid / i_out_stall), out_last set on the final
// character of the encoded message.
// Configuration: i_cfg_valid / o_cfg_ready write channel, always ready.
// Index 0 is wrap_enable, index 1 is line_groups; write only while idle.
// Each byte is classified on acceptance into one to four symbol/pad
// characters plus an optional line break and queued (QUEUE_DEPTH entries).
// The back end drains the queue into a registered output at one character
// per cycle while the receiver does not stall. With the queue empty, the first
// character of a byte passes through the queue and then the output register.
// A byte yields 1 to 6 characters, about 1.4 on average with 76-column lines,
// so the output channel sets the byte rate. A byte is taken in any cycle the
// queue has room. When the receiver stalls, the output holds and the queue
// fills, then o_in_stall rises. Reset clears the queue, the group and column
// state and the output valid, and restores wrap_enable = 1, line_groups = 19.
`default_nettype none

module base64_encoder_line_wrap_unit
    import b64lw_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire t_b64lw_in  i_in_data,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output t_b64lw_out      o_out_data,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [4:0] i_cfg_wdata
);

    t_b64lw_qstat qstat;
    t_b64lw_entry push_entry;
    t_b64lw_entry head;
    logic         push;
    logic         pop;

    b64lw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_qstat     (qstat),
        .o_push      (push),
        .o_entry     (push_entry)
    );

    b64lw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_qstat (qstat)
    );

    b64lw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_qstat     (qstat),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

/* hdl/b64lw_front.sv */
`default_nettype none

module b64lw_front
    import b64lw_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_stall,
    input  wire t_b64lw_in    i_in_data,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [4:0]   i_cfg_wdata,
    input  wire t_b64lw_qstat i_qstat,
    output logic              o_push,
    output t_b64lw_entry      o_entry
);

    localparam logic [1:0] PHASE_START = 2'd0;
    localparam logic [1:0] PHASE_ONE   = 2'd1;
    localparam logic [1:0] PHASE_TWO   = 2'd2;

    logic       r_wrap_enable;
    logic [4:0] r_line_groups;
    logic [3:0] r_carry;
    logic [1:0] r_phase;
    logic [6:0] r_col;

    logic [3:0] n_carry;
    logic [1:0] n_phase;
    logic [6:0] n_col;

    logic       accept;
    logic [1:0] phase_mid;
    logic [3:0] carry_mid;
    logic [5:0] sym0;
    logic [5:0] sym1;
    logic       group_end;
    logic [7:0] col_sum;
    logic [6:0] col_after;
    logic [7:0] b;
    logic       fin;
    t_b64lw_entry entry;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = i_qstat.full;
    assign accept      = i_in_valid && !i_qstat.full;
    assign b           = i_in_data.data_byte;
    assign fin         = i_in_data.final_byte;

    always_comb begin
        phase_mid = PHASE_ONE;
        carry_mid = {2'b00, b[1:0]};
        sym0      = b[7:2];
        sym1      = b[5:0];
        group_end = 1'b0;
        case (r_phase)
            PHASE_ONE: begin
                sym0      = {r_carry[1:0], b[7:4]};
                carry_mid = b[3:0];
                phase_mid = PHASE_TWO;
            end
            PHASE_TWO: begin
                sym0      = {r_carry[3:0], b[7:6]};
                carry_mid = 4'd0;
                phase_mid = PHASE_START;
                group_end = 1'b1;
            end
            default: begin
                sym0      = b[7:2];
                carry_mid = {2'b00, b[1:0]};
                phase_mid = PHASE_ONE;
            end
        endcase

        entry          = '0;
        entry.chars    = {4{CHAR_PAD}};
        entry.chars[0] = b64_char(sym0);
        entry.nsym     = group_end ? 3'd2 : 3'd1;
        if (group_end) begin
            entry.chars[1] = b64_char(sym1);
        end
        // flush the partial group and pad it
        if (fin) begin
            if (phase_mid == PHASE_ONE) begin
                entry.chars[1] = b64_char({carry_mid[1:0], 4'b0000});
                entry.nsym     = 3'd4;
            end else if (phase_mid == PHASE_TWO) begin
                entry.chars[1] = b64_char({carry_mid[3:0], 2'b00});
                entry.nsym     = 3'd3;
            end
        end
        entry.last = fin;

        col_sum   = {1'b0, r_col} + {5'd0, entry.nsym};
        col_after = (col_sum > {1'b0, COL_MAX}) ? COL_MAX : col_sum[6:0];

        if (fin) begin
            entry.crlf = r_wrap_enable && (col_after != 7'd0);
        end else begin
            entry.crlf = group_end && r_wrap_enable && (col_after >= {r_line_groups, 2'b00});
        end

        n_col   = (fin || entry.crlf) ? 7'd0 : col_after;
        n_phase = fin ? PHASE_START : phase_mid;
        n_carry = fin ? 4'd0 : carry_mid;
    end

    assign o_push  = accept;
    assign o_entry = entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap_enable <= 1'b1;
            r_line_groups <= 5'd19;
            r_carry       <= 4'd0;
            r_phase       <= PHASE_START;
            r_col         <= 7'd0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_WRAP_ENABLE) begin
                    r_wrap_enable <= i_cfg_wdata[0];
                end else if (i_cfg_index == CFG_LINE_GROUPS) begin
                    r_line_groups <= i_cfg_wdata;
                end
            end
            if (accept) begin
                r_carry <= n_carry;
                r_phase <= n_phase;
                r_col   <= n_col;
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/b64lw_queue.sv */
`default_nettype none

module b64lw_queue
    import b64lw_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire t_b64lw_entry  i_entry,
    input  wire logic          i_pop,
    output t_b64lw_entry       o_head,
    output t_b64lw_qstat       o_qstat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_b64lw_entry r_mem [DEPTH];

    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    assign o_head        = r_mem[r_rd_ptr];
    assign o_qstat.full  = (r_count == CNT_FULL);
    assign o_qstat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

/* hdl/b64lw_back.sv */
`default_nettype none

module b64lw_back
    import b64lw_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_b64lw_entry i_head,
    input  wire t_b64lw_qstat i_qstat,
    output logic              o_pop,
    output logic              o_out_valid,
    input  wire logic         i_out_stall,
    output t_b64lw_out        o_out_data
);

    logic       r_out_valid;
    t_b64lw_out r_out_data;
    logic [2:0] r_idx;

    logic       n_out_valid;
    t_b64lw_out n_out_data;
    logic [2:0] n_idx;

    logic       slot_free;
    logic       fire;
    logic       last_beat;
    logic [2:0] total;
    logic [7:0] sel_char;

    assign slot_free = !r_out_valid || !i_out_stall;
    assign fire      = slot_free && !i_qstat.empty;
    assign total     = i_head.nsym + (i_head.crlf ? 3'd2 : 3'd0);
    assign last_beat = (r_idx == total - 3'd1);

    always_comb begin
        if (r_idx < i_head.nsym) begin
            sel_char = i_head.chars[r_idx[1:0]];
        end else if (r_idx == i_head.nsym) begin
            sel_char = CHAR_CR;
        end else begin
            sel_char = CHAR_LF;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_idx       = r_idx;
        if (slot_free) begin
            n_out_valid = !i_qstat.empty;
        end
        if (fire) begin
            n_out_data.out_char = sel_char;
            n_out_data.out_last = i_head.last && last_beat;
            n_idx               = last_beat ? 3'd0 : r_idx + 3'd1;
        end
    end

    // retire the entry with its final beat
    assign o_pop       = fire && last_beat;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= 3'd0;
        end else begin
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
        end
    end

endmodule

`default_nettype wire

/* hdl/b64lw_checker.sv */
`default_nettype none

module b64lw_checker
    import b64lw_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire t_b64lw_out o_out_data
);

    logic [7:0] ch;
    logic       is_sym;

    assign ch     = o_out_data.out_char;
    assign is_sym = (ch >= 8'd65 && ch <= 8'd90) || (ch >= 8'd97 && ch <= 8'd122) ||
                    (ch >= 8'd48 && ch <= 8'd57) || ch == 8'd43 || ch == 8'd47;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("output beat changed under stall");

    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> is_sym || ch == CHAR_PAD || ch == CHAR_CR || ch == CHAR_LF)
        else $error("character outside Base64 output set");

    a_cr_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ch == CHAR_CR |-> !o_out_data.out_last)
        else $error("message ended on CR");

    a_cr_then_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && ch == CHAR_CR |=>
            !o_out_valid || ch == CHAR_LF)
        else $error("CR not followed by LF");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind base64_encoder_line_wrap_unit b64lw_checker u_b64lw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire

/* tb/tb_base64_encoder_line_wrap_unit.sv */
module tb_base64_encoder_line_wrap_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import b64lw_pkg::*;

    // index values that decode to no register
    localparam logic [1:0] CFG_SPARE_A = 2'd2;
    localparam logic [1:0] CFG_SPARE_B = 2'd3;

    localparam logic [0:63][7:0] SYM_TABLE =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    t_b64lw_in  in_data = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_b64lw_out out_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [4:0] cfg_wdata = '0;

    // encoder image
    logic       enc_wrap = 1'b1;
    logic [4:0] enc_groups = 5'd19;
    logic [3:0] enc_carry = '0;
    logic [1:0] enc_phase = '0;
    logic [6:0] enc_column = '0;

    t_b64lw_out expected_chars[$];
    t_b64lw_out want;
    t_b64lw_out tail;
    int         mismatch_count = 0;
    logic       calm = 1'b0;

    base64_encoder_line_wrap_unit DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial begin
        #4_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic push_raw(input logic [7:0] ch);
        begin
            expected_chars.push_back('{out_char: ch, out_last: 1'b0});
        end
    endtask

    task automatic push_char(input logic [7:0] ch);
        begin
            push_raw(ch);
            if (enc_column < COL_MAX) begin
                enc_column = enc_column + 7'd1;
            end
        end
    endtask

    task automatic push_sym(input logic [5:0] six);
        begin
            push_char(SYM_TABLE[six]);
        end
    endtask

    task automatic push_crlf;
        begin
            push_raw(CHAR_CR);
            push_raw(CHAR_LF);
            enc_column = '0;
        end
    endtask

    // work out the characters one accepted byte releases
    task automatic encode_byte(input logic [7:0] b, input logic fin);
        logic group_end;
        begin
            group_end = 1'b0;
            case (enc_phase)
                2'd1: begin
                    push_sym({enc_carry[1:0], b[7:4]});
                    enc_carry = b[3:0];
                    enc_phase = 2'd2;
                end
                2'd2: begin
                    push_sym({enc_carry, b[7:6]});
                    push_sym(b[5:0]);
                    enc_carry = '0;
                    enc_phase = 2'd0;
                    group_end = 1'b1;
                end
                default: begin
                    push_sym(b[7:2]);
                    enc_carry = {2'b00, b[1:0]};
                    enc_phase = 2'd1;
                end
            endcase
            if (fin) begin
                if (enc_phase == 2'd1) begin
                    push_sym({enc_carry[1:0], 4'b0000});
                    push_char(CHAR_PAD);
                    push_char(CHAR_PAD);
                end else if (enc_phase == 2'd2) begin
                    push_sym({enc_carry, 2'b00});
                    push_char(CHAR_PAD);
                end
                if (enc_wrap && enc_column != 0) begin
                    push_crlf();
                end
                tail = expected_chars.pop_back();
                tail.out_last = 1'b1;
                expected_chars.push_back(tail);
                enc_carry = '0;
                enc_phase = '0;
                enc_column = '0;
            end else if (group_end && enc_wrap &&
                         int'(enc_column) >= 4 * int'(enc_groups)) begin
                push_crlf();
            end
        end
    endtask

    always @(negedge clk) begin
        out_stall <= !calm && ($urandom_range(99) < 36);
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (expected_chars.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected beat: char %0d last %0b",
                             out_data.out_char, out_data.out_last);
                end
            end else begin
                want = expected_chars.pop_front();
                if (out_data.out_char !== want.out_char ||
                    out_data.out_last !== want.out_last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch: expected char %0d last %0b, got char %0d last %0b",
                                 want.out_char, want.out_last,
                                 out_data.out_char, out_data.out_last);
                    end
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic fin);
        begin
            @(negedge clk);
            while (!calm && $urandom_range(99) < 36) begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            in_valid <= 1'b1;
            in_data <= {b, fin};
            do @(posedge clk); while (in_stall);
            encode_byte(b, fin);
        end
    endtask

    task automatic send_message(input int len);
        int i;
        begin
            for (i = 0; i < len; i++) begin
                send_byte(8'($urandom_range(255)), i == len - 1);
            end
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [4:0] val);
        begin
            @(negedge clk);
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_wdata <= val;
            do @(posedge clk); while (!cfg_ready);
            case (idx)
                CFG_WRAP_ENABLE: enc_wrap = val[0];
                CFG_LINE_GROUPS: enc_groups = val;
                default: ;
            endcase
            @(negedge clk);
            cfg_valid <= 1'b0;
        end
    endtask

    // hold the sender until every expected character is out
    task automatic wait_drained;
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            while (expected_chars.size() != 0) @(posedge clk);
            repeat (4) @(posedge clk);
        end
    endtask

    task automatic test_group_tails;
        begin
            send_byte(8'h00, 1'b1);
            send_byte(8'hFF, 1'b0);
            send_byte(8'hFF, 1'b1);
            send_byte(8'hFB, 1'b0);
            send_byte(8'hEF, 1'b0);
            send_byte(8'hBE, 1'b1);
            send_byte(8'h00, 1'b0);
            send_byte(8'h10, 1'b0);
            send_byte(8'h83, 1'b0);
            send_byte(8'hFF, 1'b1);
            wait_drained();
        end
    endtask

    task automatic test_short_lines;
        begin
            write_reg(CFG_LINE_GROUPS, 5'd0);
            send_message(3);
            wait_drained();
            write_reg(CFG_LINE_GROUPS, 5'd1);
            send_message(3);
            wait_drained();
            write_reg(CFG_LINE_GROUPS, 5'd31);
            write_reg(CFG_SPARE_A, 5'd0);
            write_reg(CFG_SPARE_B, 5'd31);
            send_message(4);
            wait_drained();
            write_reg(CFG_WRAP_ENABLE, 5'b11110);
            send_message(2);
            wait_drained();
            write_reg(CFG_WRAP_ENABLE, 5'b00001);
        end
    endtask

    // shorten the line while one is open: break at the next group end
    task automatic test_midline_limit;
        int i;
        begin
            write_reg(CFG_LINE_GROUPS, 5'd19);
            for (i = 0; i < 6; i++) begin
                send_byte(8'($urandom_range(255)), 1'b0);
            end
            wait_drained();
            write_reg(CFG_LINE_GROUPS, 5'd2);
            for (i = 0; i < 3; i++) begin
                send_byte(8'($urandom_range(255)), 1'b0);
            end
            send_byte(8'($urandom_range(255)), 1'b1);
            wait_drained();
        end
    endtask

    // run the column past its ceiling in plain mode, then turn wrapping on
    task automatic test_plain_saturation;
        int i;
        begin
            calm = 1'b1;
            write_reg(CFG_WRAP_ENABLE, 5'd0);
            write_reg(CFG_LINE_GROUPS, 5'd19);
            for (i = 0; i < 96; i++) begin
                send_byte(8'($urandom_range(255)), 1'b0);
            end
            calm = 1'b0;
            wait_drained();
            write_reg(CFG_WRAP_ENABLE, {4'($urandom_range(15)), 1'b1});
            for (i = 0; i < 4; i++) begin
                send_byte(8'($urandom_range(255)), i == 3);
            end
            wait_drained();
        end
    endtask

    task automatic test_random_messages;
        int         phase;
        int         sent;
        int         len;
        int         i;
        logic       open_end;
        logic       wrap_on;
        logic [4:0] grp;
        begin
            for (phase = 0; phase < 7; phase++) begin
                case (phase)
                    0: begin wrap_on = 1'b1; grp = 5'd19; end
                    1: begin wrap_on = 1'b1; grp = 5'd0; end
                    2: begin wrap_on = 1'b0; grp = 5'($urandom_range(31)); end
                    3: begin wrap_on = 1'b1; grp = 5'd31; end
                    4: begin wrap_on = 1'b1; grp = 5'd1; end
                    default: begin
                        wrap_on = 1'($urandom_range(1));
                        grp = 5'($urandom_range(1, 6));
                    end
                endcase
                write_reg(CFG_WRAP_ENABLE, {4'($urandom_range(15)), wrap_on});
                write_reg(CFG_LINE_GROUPS, grp);
                calm = (phase == 5);
                sent = 0;
                while (sent < 3) begin
                    len = ($urandom_range(9) < 7) ? $urandom_range(1, 3)
                                                  : $urandom_range(4, 8);
                    // now and then leave the message open across the phase change
                    open_end = (sent + len >= 3) && ($urandom_range(3) == 0);
                    for (i = 0; i < len; i++) begin
                        send_byte(8'($urandom_range(255)), (i == len - 1) && !open_end);
                        if (phase == 6 && i == len / 2) begin
                            wait_drained();
                        end
                    end
                    sent += len;
                end
                calm = 1'b0;
                wait_drained();
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_group_tails();
        test_short_lines();
        test_midline_limit();
        test_plain_saturation();
        test_random_messages();
        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
